// File: sv/mng_pkg.sv
`default_nettype none

package mng_pkg;

  localparam int SYMBOLS   = 28;
  localparam int SLOT_BITS = 5;

  localparam logic [4:0] SYM_END   = 5'd0;
  localparam logic [4:0] SYM_SPACE = 5'd27;

  localparam logic [1:0] FUNC_TRAIN    = 2'd0;
  localparam logic [1:0] FUNC_GENERATE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR    = 2'd2;
  localparam logic [1:0] FUNC_NONE     = 2'd3;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;

  localparam logic [2:0] CTX_LEN_RESET = 3'd2;

  typedef struct packed {
    logic       hit;
    logic       last;
    logic [4:0] sym;
  } acc_status_t;

endpackage

`default_nettype wire

// File: sv/mng_ram.sv
`default_nettype none

module mng_ram #(
  parameter int DEPTH = 784,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: sv/mng_acc.sv
`default_nettype none

module mng_acc #(
  parameter int COUNT_BITS = 16,
  parameter int LHS_W      = 37
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    load,
  input  wire logic [LHS_W-1:0]        lhs,
  input  wire logic                    in_valid,
  input  wire logic [COUNT_BITS-1:0]   in_data,
  input  wire logic [4:0]              in_sym,
  output mng_pkg::acc_status_t         status
);

  import mng_pkg::*;

  localparam int W_W   = COUNT_BITS + 16;
  localparam int ACC_W = LHS_W + 1;

  logic             wv;
  logic [W_W-1:0]   w;
  logic [4:0]       wsym;
  logic [ACC_W-1:0] acc;
  logic [ACC_W-1:0] acc_next;

  // acc holds 65535*c - r*total; the symbol is taken once it stops being negative
  assign acc_next = acc + ACC_W'(w);

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= 1'b0;
    end else begin
      wv <= load ? 1'b0 : in_valid;
    end
  end

  always_ff @(posedge clk) begin
    w    <= {in_data, 16'h0000} - W_W'(in_data);
    wsym <= in_sym;
    if (load) begin
      acc <= ACC_W'(0) - {1'b0, lhs};
    end else if (wv) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    status.hit  = wv && !acc_next[ACC_W-1];
    status.last = wv && (wsym == SYM_SPACE);
    status.sym  = wsym;
  end

endmodule

`default_nettype wire

// File: sv/markov_ngram_word_generator_unit.sv
`default_nettype none

// n-gram symbol generator over a 28-symbol alphabet (word end, a-z, space).
// A request is taken when start is high and busy is low. Training goes through row
// index, counter read and counter write; generation through row index, total read,
// product and accumulator load, ending there for an unseen context, and otherwise
// walks the row's counters one per cycle through the count memory read port, summed
// by a single accumulate and compare unit. Clear, and the sweep after reset, zero
// the count memory one entry per cycle over its 28**(MAX_CONTEXT+1) entries, 21952
// at the default, with busy high. A generated symbol is shown for exactly one cycle
// with strobe high and cannot be held off, so the receiver must take it then.
// The context length register may be written at any time the block is idle.
module markov_ngram_word_generator_unit #(
  parameter int MAX_CONTEXT = 2,
  parameter int COUNT_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] func,
  input  wire logic [7:0] raw_byte,
  input  wire logic [15:0] random_value,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_wdata,
  output logic            strobe,
  output logic [4:0]      symbol,
  output logic [6:0]      ascii_char,
  output logic            word_end
);

  import mng_pkg::*;

  localparam int ROWS    = SYMBOLS ** MAX_CONTEXT;
  localparam int ENTRIES = ROWS * SYMBOLS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int TOT_W   = COUNT_BITS + 5;
  localparam int LHS_W   = TOT_W + 16;
  localparam int CTX_W   = SLOT_BITS * MAX_CONTEXT;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_ROW    = 9'b000000100,
    S_T_RD   = 9'b000001000,
    S_T_WR   = 9'b000010000,
    S_G_RD   = 9'b000100000,
    S_G_MUL  = 9'b001000000,
    S_G_INIT = 9'b010000000,
    S_G_WALK = 9'b100000000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] clr;
  logic [ROW_W-1:0]  row;
  logic [ADDR_W-1:0] base;
  logic [4:0]        sym_q;
  logic [15:0]       rand_q;
  logic              is_gen;
  logic [CTX_W-1:0]  tctx;
  logic [CTX_W-1:0]  gctx;
  logic [2:0]        context_length;
  logic [LHS_W-1:0]  prod;
  logic              tot_zero;
  logic [4:0]        rk;
  logic              issuing;
  logic              rv;
  logic [4:0]        rsym;

  logic [2:0]        eff;
  logic [CTX_W-1:0]  mask;
  logic [CTX_W-1:0]  tmask;
  logic [CTX_W-1:0]  gmask;
  logic [CTX_W-1:0]  sel_ctx;
  logic [ROW_W-1:0]  row_sum;
  logic [ROW_W:0]    wt;
  logic [4:0]        slot;

  logic [7:0]        folded;
  logic              is_letter;
  logic [4:0]        dsym;

  logic [ADDR_W-1:0] row_base;
  logic [ADDR_W-1:0] train_addr;
  logic [ADDR_W-1:0] cnt_raddr;
  logic [ADDR_W-1:0] cnt_waddr;
  logic              cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [ROW_W-1:0]  tot_waddr;
  logic              tot_we;
  logic [TOT_W-1:0]  tot_wdata;
  logic [TOT_W-1:0]  tot_rdata;
  logic              can_count;
  logic              clear_done;

  logic              fin;
  logic [4:0]        fin_sym;
  logic [CTX_W+SLOT_BITS-1:0] t_cat;
  logic [CTX_W+SLOT_BITS-1:0] g_cat;
  logic [CTX_W-1:0]  t_shift;
  logic [CTX_W-1:0]  g_shift;

  acc_status_t       status;

  function automatic logic [6:0] sym_to_ascii(input logic [4:0] s);
    logic [6:0] a;
    if (s == SYM_END) begin
      a = CHAR_NEWLINE[6:0];
    end else if (s == SYM_SPACE) begin
      a = CHAR_SPACE[6:0];
    end else begin
      a = 7'(CHAR_LOWER_A - 8'd1 + 8'(s));
    end
    return a;
  endfunction

  assign busy = (state != S_IDLE);

  // effective context length and slot mask
  always_comb begin
    if (context_length == 3'd0) begin
      eff = 3'd1;
    end else if (context_length > 3'(MAX_CONTEXT)) begin
      eff = 3'(MAX_CONTEXT);
    end else begin
      eff = context_length;
    end
    for (int k = 0; k < MAX_CONTEXT; k++) begin
      mask[k*SLOT_BITS +: SLOT_BITS] = (3'(k) < eff) ? {SLOT_BITS{1'b1}} : '0;
    end
  end

  assign tmask   = tctx & mask;
  assign gmask   = gctx & mask;
  assign sel_ctx = is_gen ? gmask : tmask;

  // row index: base-28 number made of the context slots
  always_comb begin
    row_sum = '0;
    wt      = (ROW_W + 1)'(1);
    slot    = '0;
    for (int k = 0; k < MAX_CONTEXT; k++) begin
      slot = sel_ctx[k*SLOT_BITS +: SLOT_BITS];
      if (slot > SYM_SPACE) begin
        slot = SYM_SPACE;
      end
      row_sum = ROW_W'(row_sum + ROW_W'(slot) * wt[ROW_W-1:0]);
      wt      = (ROW_W + 1)'(wt * SYMBOLS);
    end
  end

  // byte decode: fold case, then letter or space
  always_comb begin
    if (raw_byte >= CHAR_UPPER_A && raw_byte <= CHAR_UPPER_Z) begin
      folded = raw_byte + CASE_OFFSET;
    end else begin
      folded = raw_byte;
    end
    is_letter = (folded >= CHAR_LOWER_A) && (folded <= CHAR_LOWER_Z);
    dsym      = 5'(folded - CHAR_LOWER_A + 8'd1);
  end

  assign row_base   = ADDR_W'({row, 5'b00000}) - ADDR_W'({row, 2'b00});
  assign train_addr = ADDR_W'(row_base + ADDR_W'(sym_q));
  assign cnt_raddr  = (state == S_G_WALK) ? ADDR_W'(base + ADDR_W'(rk)) : train_addr;

  assign can_count  = (state == S_T_WR) && (cnt_rdata != COUNT_MAX);
  assign clear_done = (clr == ADDR_W'(ENTRIES - 1));

  always_comb begin
    if (state == S_CLEAR) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr;
      cnt_wdata = '0;
      tot_we    = (clr < ADDR_W'(ROWS));
      tot_waddr = clr[ROW_W-1:0];
      tot_wdata = '0;
    end else begin
      cnt_we    = can_count;
      cnt_waddr = train_addr;
      cnt_wdata = cnt_rdata + COUNT_BITS'(1);
      tot_we    = can_count;
      tot_waddr = row;
      tot_wdata = tot_rdata + TOT_W'(1);
    end
  end

  mng_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (COUNT_BITS)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mng_ram #(
    .DEPTH (ROWS),
    .WIDTH (TOT_W)
  ) u_totals (
    .clk   (clk),
    .we    (tot_we),
    .waddr (tot_waddr),
    .wdata (tot_wdata),
    .raddr (row),
    .rdata (tot_rdata)
  );

  mng_acc #(
    .COUNT_BITS (COUNT_BITS),
    .LHS_W      (LHS_W)
  ) u_acc (
    .clk      (clk),
    .rst      (rst),
    .load     (state == S_G_INIT),
    .lhs      (prod),
    .in_valid (rv),
    .in_data  (cnt_rdata),
    .in_sym   (rsym),
    .status   (status)
  );

  assign fin = ((state == S_G_INIT) && tot_zero) ||
               ((state == S_G_WALK) && (status.hit || status.last));
  assign fin_sym = (state == S_G_INIT) ? SYM_END : status.sym;

  assign t_cat   = {tmask, sym_q};
  assign t_shift = t_cat[CTX_W-1:0] & mask;
  assign g_cat   = {gmask, fin_sym};
  assign g_shift = g_cat[CTX_W-1:0] & mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr            <= '0;
      tctx           <= '0;
      gctx           <= '0;
      context_length <= CTX_LEN_RESET;
      strobe         <= 1'b0;
      rv             <= 1'b0;
      issuing        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      rv     <= 1'b0;
      if (cfg_we) begin
        context_length <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            rand_q <= random_value;
            case (func)
              FUNC_TRAIN: begin
                is_gen <= 1'b0;
                if (is_letter) begin
                  sym_q <= dsym;
                  state <= S_ROW;
                end else if (folded == CHAR_SPACE) begin
                  sym_q <= SYM_SPACE;
                  state <= S_ROW;
                end else if (folded == CHAR_NEWLINE) begin
                  // a newline at the start of a line is not counted
                  if (tmask != '0) begin
                    sym_q <= SYM_END;
                    state <= S_ROW;
                  end else begin
                    tctx <= '0;
                  end
                end
              end
              FUNC_GENERATE: begin
                is_gen <= 1'b1;
                state  <= S_ROW;
              end
              FUNC_CLEAR: begin
                tctx  <= '0;
                gctx  <= '0;
                clr   <= '0;
                state <= S_CLEAR;
              end
              FUNC_NONE: begin
              end
              default: begin
              end
            endcase
          end
        end
        S_CLEAR: begin
          clr <= clr + ADDR_W'(1);
          if (clear_done) begin
            state <= S_IDLE;
          end
        end
        S_ROW: begin
          row   <= row_sum;
          state <= is_gen ? S_G_RD : S_T_RD;
        end
        S_T_RD: begin
          state <= S_T_WR;
        end
        S_T_WR: begin
          tctx  <= (sym_q == SYM_END) ? '0 : t_shift;
          state <= S_IDLE;
        end
        S_G_RD: begin
          base  <= row_base;
          state <= S_G_MUL;
        end
        S_G_MUL: begin
          prod     <= LHS_W'(rand_q) * LHS_W'(tot_rdata);
          tot_zero <= (tot_rdata == '0);
          state    <= S_G_INIT;
        end
        S_G_INIT: begin
          rk      <= '0;
          issuing <= 1'b1;
          state   <= S_G_WALK;
        end
        S_G_WALK: begin
          if (issuing) begin
            rv   <= 1'b1;
            rsym <= rk;
            rk   <= rk + 5'd1;
            if (rk == SYM_SPACE) begin
              issuing <= 1'b0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (fin) begin
        strobe     <= 1'b1;
        symbol     <= fin_sym;
        ascii_char <= sym_to_ascii(fin_sym);
        word_end   <= (fin_sym == SYM_END);
        gctx       <= (fin_sym == SYM_END) ? '0 : g_shift;
        issuing    <= 1'b0;
        state      <= S_IDLE;
      end
    end
  end

endmodule

`default_nettype wire
